// File: hw/rtl/frrt_pkg.sv
// Shared types and constants of the firewall range rule table.
package frrt_pkg;

   localparam int RULE_SLOTS = 64;
   localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_CHECK = 2'd2;

   localparam logic [2:0] ST_ADDED = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_DELETED = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_ACCEPTED = 3'd4;
   localparam logic [2:0] ST_REJECTED = 3'd5;
   localparam logic [2:0] ST_FULL = 3'd6;

   typedef struct packed {
      logic [31:0] ip_low;
      logic [31:0] ip_high;
      logic [15:0] port_low;
      logic [15:0] port_high;
   } rule_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic       bad_req;
      logic       hit;
      logic       last;
      logic       issue_last;
      logic [1:0] action;
   } dp_stat_type;

endpackage

// File: hw/rtl/frrt_dp.sv
// Datapath of the rule table: request registers, rule memory, valid bits and slot compare.
module frrt_dp
   import frrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_ip_start,
   input  logic [31:0] req_ip_end,
   input  logic [15:0] req_port_start,
   input  logic [15:0] req_port_end,
   input  logic [31:0] req_query_ip,
   input  logic [15:0] req_query_port
);

   rule_type              rule_mem [RULE_SLOTS];
   logic [RULE_SLOTS-1:0] slot_valid_ff;

   logic [1:0]  action_ff;
   rule_type    req_rule_ff;
   logic [31:0] query_ip_ff;
   logic [15:0] query_port_ff;

   logic [SLOT_W-1:0] issue_addr_ff;
   logic [SLOT_W-1:0] cmp_idx_ff;
   logic              cmp_vld_ff;
   rule_type          rd_rule_ff;
   logic              rd_valid_ff;

   logic equal_match;
   logic range_match;
   logic slot_hit;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         req_rule_ff <= '{ip_low: req_ip_start, ip_high: req_ip_end,
                           port_low: req_port_start, port_high: req_port_end};
         query_ip_ff <= req_query_ip;
         query_port_ff <= req_query_port;
      end
      if (cmd.issue) begin
         rd_rule_ff <= rule_mem[issue_addr_ff];
         rd_valid_ff <= slot_valid_ff[issue_addr_ff];
         cmp_idx_ff <= issue_addr_ff;
      end
      if (cmd.commit && action_ff == ACT_ADD) begin
         rule_mem[cmp_idx_ff] <= req_rule_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         cmp_vld_ff <= 1'b0;
         issue_addr_ff <= '0;
      end else begin
         cmp_vld_ff <= cmd.issue;
         if (cmd.load) begin
            issue_addr_ff <= '0;
         end else if (cmd.issue) begin
            issue_addr_ff <= issue_addr_ff + 1'b1;
         end
         if (cmd.commit) begin
            slot_valid_ff[cmp_idx_ff] <= (action_ff == ACT_ADD);
         end
      end
   end

   assign equal_match = (rd_rule_ff == req_rule_ff);
   assign range_match = (query_ip_ff >= rd_rule_ff.ip_low) &&
                        (query_ip_ff <= rd_rule_ff.ip_high) &&
                        (query_port_ff >= rd_rule_ff.port_low) &&
                        (query_port_ff <= rd_rule_ff.port_high);

   always_comb begin
      case (action_ff)
         ACT_ADD:    slot_hit = !rd_valid_ff;
         ACT_DELETE: slot_hit = rd_valid_ff && equal_match;
         ACT_CHECK:  slot_hit = rd_valid_ff && range_match;
         default:    slot_hit = 1'b0;
      endcase
   end

   assign stat.bad_req = (req_action != ACT_ADD && req_action != ACT_DELETE &&
                          req_action != ACT_CHECK) ||
                         (req_action == ACT_ADD && (req_ip_start > req_ip_end ||
                                                   req_port_start > req_port_end));
   assign stat.hit = cmp_vld_ff && slot_hit;
   assign stat.last = cmp_vld_ff && (cmp_idx_ff == SLOT_W'(RULE_SLOTS - 1));
   assign stat.issue_last = (issue_addr_ff == SLOT_W'(RULE_SLOTS - 1));
   assign stat.action = action_ff;

endmodule

// File: hw/rtl/frrt_ctrl.sv
// Controller of the rule table: request acceptance, slot scan sequencing and result strobe.
module frrt_ctrl
   import frrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status
);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type  state_ff, state_in;
   logic       issuing_ff, issuing_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [2:0] hit_status;
   logic [2:0] miss_status;

   always_comb begin
      case (stat.action)
         ACT_ADD: begin
            hit_status = ST_ADDED;
            miss_status = ST_FULL;
         end
         ACT_DELETE: begin
            hit_status = ST_DELETED;
            miss_status = ST_NOTFOUND;
         end
         ACT_CHECK: begin
            hit_status = ST_ACCEPTED;
            miss_status = ST_REJECTED;
         end
         default: begin
            hit_status = ST_INVALID;
            miss_status = ST_INVALID;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign cmd.load = (state_ff == S_IDLE) && start;
   assign cmd.issue = (state_ff == S_SCAN) && issuing_ff;
   assign cmd.commit = (state_ff == S_SCAN) && stat.hit && (stat.action != ACT_CHECK);

   always_comb begin
      state_in = state_ff;
      issuing_in = issuing_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (stat.bad_req) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = ST_INVALID;
               end else begin
                  state_in = S_SCAN;
                  issuing_in = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (cmd.issue && stat.issue_last) begin
               issuing_in = 1'b0;
            end
            if (stat.hit) begin
               state_in = S_IDLE;
               issuing_in = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_status_in = hit_status;
            end else if (stat.last) begin
               state_in = S_IDLE;
               issuing_in = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_status_in = miss_status;
            end
         end
         default: begin
            state_in = S_IDLE;
            issuing_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         issuing_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_status_ff <= ST_ADDED;
      end else begin
         state_ff <= state_in;
         issuing_ff <= issuing_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: hw/rtl/firewall_range_rule_table_top.sv
// Top level of the firewall range rule table.
// A malformed request (unknown action, or an add with an inverted range) answers in the cycle
// after its transfer and leaves busy low. Other requests scan one rule slot per cycle through
// the rule memory's read port: the answer is registered once the first slot that decides it has
// been read and compared, or once the last slot has been compared when none does; busy stays high
// until that answer. Reset clears all valid bits at once and needs no clearing pass.
module firewall_range_rule_table_top
   import frrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_ip_start,
   input  logic [31:0] req_ip_end,
   input  logic [15:0] req_port_start,
   input  logic [15:0] req_port_end,
   input  logic [31:0] req_query_ip,
   input  logic [15:0] req_query_port,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   frrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status)
   );

   frrt_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_action),
      .req_ip_start   (req_ip_start),
      .req_ip_end     (req_ip_end),
      .req_port_start (req_port_start),
      .req_port_end   (req_port_end),
      .req_query_ip   (req_query_ip),
      .req_query_port (req_query_port)
   );

endmodule
